[hdl/csvtok_pkg.sv]
// Shared types and constants for the CSV/TSV tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package csvtok_pkg;

  localparam int UnitWidth = 16;

  localparam logic [UnitWidth-1:0] CH_QUOTE   = 16'd34;
  localparam logic [UnitWidth-1:0] CH_LF      = 16'd10;
  localparam logic [UnitWidth-1:0] CH_CR      = 16'd13;
  localparam logic [UnitWidth-1:0] SEP_RESET  = 16'd44;

  // Result kinds as they appear on the output.
  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CELL   = 2'd1,
    KIND_RECORD = 2'd2
  } kind_t;

  // Quoting mode, one-hot.
  typedef enum logic [2:0] {
    MODE_OUT   = 3'b001,
    MODE_IN    = 3'b010,
    MODE_QSEEN = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  cell_nonempty;
    logic  row_started;
    logic  row_value_seen;
    logic  header_passed;
  } tok_state_t;

  localparam tok_state_t STATE_RESET = '{
    mode:           MODE_OUT,
    cell_nonempty:  1'b0,
    row_started:    1'b0,
    row_value_seen: 1'b0,
    header_passed:  1'b0
  };

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [UnitWidth-1:0] ch;
    logic                 has_value;
    logic                 header;
  } tok_result_t;

endpackage

`default_nettype wire

[hdl/csvtok_space.sv]
// Whitespace classifier for one UTF-16 code unit.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_space (
  input  wire logic [csvtok_pkg::UnitWidth-1:0] unit,
  output logic                                  is_space
);
  import csvtok_pkg::*;

  always_comb begin
    is_space = (unit >= 16'd9 && unit <= 16'd13)
            || unit == 16'd32 || unit == 16'd133 || unit == 16'd160
            || unit == 16'd5760
            || (unit >= 16'd8192 && unit <= 16'd8202)
            || unit == 16'd8232 || unit == 16'd8233 || unit == 16'd8239
            || unit == 16'd8287 || unit == 16'd12288;
  end

endmodule

`default_nettype wire

[hdl/csvtok_step.sv]
// Tokenizer state register and the per-word next-state / result logic.
// Depends on csvtok_pkg and csvtok_space.
`default_nettype none

module csvtok_step (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  advance,
  input  wire logic [csvtok_pkg::UnitWidth-1:0]      unit,
  input  wire logic                                  eot,
  input  wire logic [csvtok_pkg::UnitWidth-1:0]      separator,
  output csvtok_pkg::tok_result_t                    result
);
  import csvtok_pkg::*;

  tok_state_t state;
  tok_state_t state_next;
  logic       unit_space;
  logic       go_outside;

  csvtok_space u_space (
    .unit     (unit),
    .is_space (unit_space)
  );

  always_comb begin
    state_next = state;
    result     = '{valid: 1'b0, kind: KIND_CHAR, ch: '0, has_value: 1'b0, header: 1'b0};
    go_outside = 1'b0;

    if (eot) begin
      // Close a partial row, then start over as a fresh text.
      if (state.cell_nonempty || state.row_started) begin
        result.valid     = 1'b1;
        result.kind      = KIND_RECORD;
        result.has_value = state.row_value_seen;
        result.header    = !state.header_passed;
      end
      state_next = STATE_RESET;
    end else begin
      case (state.mode)
        MODE_IN: begin
          if (unit == CH_QUOTE) begin
            state_next.mode = MODE_QSEEN;
          end else begin
            result.valid = 1'b1;
            result.ch    = unit;
            state_next.cell_nonempty = 1'b1;
            if (!unit_space) state_next.row_value_seen = 1'b1;
          end
        end
        MODE_QSEEN: begin
          if (unit == CH_QUOTE) begin
            // Doubled quote: one literal quote, stay quoted.
            state_next.mode = MODE_IN;
            result.valid = 1'b1;
            result.ch    = CH_QUOTE;
            state_next.cell_nonempty  = 1'b1;
            state_next.row_value_seen = 1'b1;
          end else begin
            go_outside = 1'b1;
          end
        end
        default: go_outside = 1'b1;
      endcase

      if (go_outside) begin
        state_next.mode = MODE_OUT;
        if (unit == CH_QUOTE) begin
          state_next.mode = MODE_IN;
        end else if (unit == separator) begin
          state_next.cell_nonempty = 1'b0;
          state_next.row_started   = 1'b1;
          result.valid = 1'b1;
          result.kind  = KIND_CELL;
        end else if (unit == CH_LF) begin
          result.valid     = 1'b1;
          result.kind      = KIND_RECORD;
          result.has_value = state.row_value_seen;
          result.header    = !state.header_passed;
          state_next.header_passed  = 1'b1;
          state_next.cell_nonempty  = 1'b0;
          state_next.row_started    = 1'b0;
          state_next.row_value_seen = 1'b0;
        end else if (unit != CH_CR) begin
          result.valid = 1'b1;
          result.ch    = unit;
          state_next.cell_nonempty = 1'b1;
          if (!unit_space) state_next.row_value_seen = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hdl/csv_quoted_field_tokenizer.sv]
// Top level of the CSV/TSV quoted-field tokenizer: input register, step logic,
// result register. Depends on csvtok_pkg, csvtok_step and csvtok_space.
//
// Usage:
//   Slave stream (s_*): one word per code unit. s_tdata carries the UTF-16
//   code unit, s_tlast set means end of text (no character; close any partial
//   row and return to the start of a new text whose first record is a header).
//   Master stream (m_*): at most one word per input word. m_tuser is the
//   event kind (0 cell character, 1 end of cell, 2 end of cell and record),
//   m_tdata holds the character and, for end of record, the has-value and
//   header flags. Words that cause no result (opening or closing quote,
//   carriage return outside quotes, an empty end of text) simply vanish.
//   Configuration: pulse cfg_we with cfg_wdata to set the field separator
//   (44 comma after reset, 9 for tab separated text). Write it only while
//   the block is idle.
// Timing:
//   A word accepted on s_* waits in the input register; its result is
//   captured in the result register, which drives m_*.
//   Throughput is one word per cycle while m_tready holds; the only loop
//   is the small tokenizer state update between the input and state registers.
// Reset (rst, synchronous): both stages empty, tokenizer state cleared, the
//   separator back to comma. When the receiver stalls, the result register
//   holds its word; the input register still drains words that give no
//   result, otherwise s_tready drops until m_tready frees the result stage.
`default_nettype none

module csv_quoted_field_tokenizer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration
  input  wire logic                                 cfg_we,
  input  wire logic [csvtok_pkg::UnitWidth-1:0]     cfg_wdata,
  // Input stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [15:0]                          s_tdata,   // [15:0] code_unit
  input  wire logic                                 s_tlast,   // end_of_text
  // Result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [23:0]                               m_tdata,   // [15:0] cell_char,
                                                               // [16] row_has_value,
                                                               // [17] header_row,
                                                               // [23:18] zero
  output logic [1:0]                                m_tuser    // [1:0] event_kind
);
  import csvtok_pkg::*;

  logic                 separator_valid_unused;
  logic [UnitWidth-1:0] separator;

  // Input register
  logic                 in_valid;
  logic [UnitWidth-1:0] in_unit;
  logic                 in_eot;

  // Result register
  logic                 out_valid;
  kind_t                out_kind;
  logic [UnitWidth-1:0] out_char;
  logic                 out_has_value;
  logic                 out_header;

  tok_result_t result;
  logic        out_free;
  logic        advance;

  assign separator_valid_unused = 1'b0;

  // Advance the input stage when the result stage can take the word, or when
  // the word yields nothing.
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && (out_free || !result.valid);
  assign s_tready = !in_valid || advance;

  csvtok_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .unit      (in_unit),
    .eot       (in_eot),
    .separator (separator),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEP_RESET;
    end else if (cfg_we) begin
      separator <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_unit <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_kind      <= result.kind;
      out_char      <= result.ch;
      out_has_value <= result.has_value;
      out_header    <= result.header;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {5'd0, separator_valid_unused, out_header, out_has_value, out_char};

endmodule

`default_nettype wire
